/* hdl/ato_pkg.sv */
// Shared constants, types and the elaboration-time sine function for the
// additive triangle oscillator. No dependencies.
package ato_pkg;

  localparam int unsigned STEP_W   = 31;  // phase step field
  localparam int unsigned SAMPLE_W = 16;  // output sample field
  localparam int unsigned GAIN_W   = 16;  // Q0.16 gain register
  localparam int unsigned COEF_W   = 31;  // Q30 harmonic weight, 2^30 for h = 1
  localparam int unsigned SINE_W   = 15;  // Q15 sine magnitude
  localparam int unsigned PROD_W   = COEF_W + SINE_W;
  localparam int unsigned ACC_W    = 48;  // Q45 sum, bounded below 2^46
  localparam int unsigned SCL_LO_W = 24;  // split of the sum for the 8/pi^2 scale
  localparam int unsigned SCL_P_W  = 40;  // one partial product of that scale
  localparam int unsigned M1_W     = 32;  // scaled Q30 magnitude
  localparam int unsigned M2_W     = 17;  // gained Q15 magnitude
  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [GAIN_W-1:0]   GAIN_RESET    = 16'd6554;
  localparam logic [15:0]         TRI_SCALE_Q16 = 16'd53121;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = 16'h7FFF;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = 16'h8000;

  localparam logic [63:0] SIN_C1 = 64'd1686629713;
  localparam logic [63:0] SIN_C3 = 64'd693598669;
  localparam logic [63:0] SIN_C5 = 64'd85569305;
  localparam logic [63:0] SIN_C7 = 64'd5026995;
  localparam logic [63:0] SIN_C9 = 64'd172272;

  // Back-end status seen by the top level
  typedef struct packed {
    logic busy;
    logic result_pending;
  } bk_stat_t;

  // Quarter-wave sine magnitude at position pos of 2^qbits, Q15.
  // Odd polynomial in Q30, every product truncated, result rounded.
  function automatic logic [SINE_W-1:0] sine_mag(input logic [31:0] pos,
                                                 input logic [31:0] qbits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] p;
    logic [63:0] s;
    x  = 64'(pos) << (32'd30 - qbits);
    x2 = (x * x) >> 30;
    p  = SIN_C7 - ((x2 * SIN_C9) >> 30);
    p  = SIN_C5 - ((x2 * p) >> 30);
    p  = SIN_C3 - ((x2 * p) >> 30);
    p  = SIN_C1 - ((x2 * p) >> 30);
    s  = (((x * p) >> 30) + 64'd16384) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_W-1:0];
  endfunction

endpackage

/* hdl/ato_if.sv */
// Valid/ready channel interfaces for the oscillator: phase step in, sample out.
// Depends on ato_pkg.
interface ato_in_if;
  import ato_pkg::*;
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] phase_step;
  modport source (output valid, output phase_step, input ready);
  modport sink (input valid, input phase_step, output ready);
endinterface

interface ato_out_if;
  import ato_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

/* hdl/additive_triangle_oscillator.sv */
// Band-limited additive triangle oscillator.
//
// in_i  : one phase step per sample tick (fraction of a cycle over 2^PHASE_BITS).
// out_o : one signed Q1.15 sample per accepted step, in order.
// cfg_we_i / cfg_wdata_i : write the Q0.16 output gain; write only while idle.
//
// The front end takes a step whenever the two-entry queue has room and
// advances the phase accumulator at once. The back end sums one odd
// harmonic per cycle (one weight ROM and one sine ROM read per cycle)
// over every odd harmonic that falls below half a cycle, at most
// MAX_ODD_HARMONICS of them, then scales the sum. Steps of half a cycle
// or more skip the sum and give zero. The back end takes a new item only
// after its last result has been loaded into the output register.
//
// Reset clears the phase, the queue and the output valid flag, and loads
// the gain with about 0.1. A stalled receiver holds the sample in the output
// register; the back end then waits with its next result, and the queue
// keeps accepting until it is full.
module additive_triangle_oscillator #(
  parameter int unsigned MAX_ODD_HARMONICS = 512,
  parameter int unsigned SINE_TABLE_BITS   = 10,
  parameter int unsigned PHASE_BITS        = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ato_in_if.sink                     in_i,
  ato_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [ato_pkg::GAIN_W-1:0] cfg_wdata_i
);
  import ato_pkg::*;

  localparam int unsigned DW = 2 * PHASE_BITS + 1;

  logic [GAIN_W-1:0] gain_q;
  logic              push_valid;
  logic              push_ready;
  logic [DW-1:0]     push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [DW-1:0]     pop_data;
  bk_stat_t          bk_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  ato_front #(
    .PB (PHASE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  ato_fifo #(
    .W (DW)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  ato_back #(
    .PB   (PHASE_BITS),
    .STB  (SINE_TABLE_BITS),
    .MAXH (MAX_ODD_HARMONICS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .gain_i      (gain_q),
    .out_o       (out_o),
    .stat_o      (bk_stat)
  );

`ifndef ASSERT_OFF
  a_in_reaches_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> pop_valid)
    else $error("accepted step did not reach the queue");

  a_pop_starts_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |=> bk_stat.busy)
    else $error("back end idle after taking an item");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(bk_stat.busy))
    else $error("result appeared without back-end work");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(bk_stat.result_pending) |-> out_o.valid)
    else $error("finished result not held in output register");
`endif

endmodule

/* hdl/ato_front.sv */
// Front end: takes phase steps, keeps the phase accumulator and tags
// steps that reach half a cycle. Depends on ato_pkg and ato_if.
module ato_front #(
  parameter int unsigned PB = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ato_in_if.sink      in_i,
  output logic        push_valid_o,
  input  logic        push_ready_i,
  output logic [2*PB:0] push_data_o
);
  import ato_pkg::*;

  localparam int unsigned SW = (PB < STEP_W) ? PB : STEP_W;

  logic [PB-1:0] phase_q;
  logic [PB-1:0] phase_d;
  logic [PB-1:0] step;
  logic          accept;

  assign step         = PB'(in_i.phase_step[SW-1:0]);
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign accept       = in_i.valid && push_ready_i;

  // Top bit set means no harmonic fits below half a cycle: mute the item
  assign push_data_o = {step[PB-1], step, phase_q};

  assign phase_d = phase_q + step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
    end
  end

endmodule

/* hdl/ato_fifo.sv */
// Two-entry queue between the front and back ends.
// Depends on ato_pkg.
module ato_fifo #(
  parameter int unsigned W = 65
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  logic [W-1:0] push_data_i,
  output logic         pop_valid_o,
  input  logic         pop_ready_i,
  output logic [W-1:0] pop_data_o
);
  import ato_pkg::*;

  logic [W-1:0] mem_q [FIFO_DEPTH];
  logic         wr_q;
  logic         rd_q;
  logic [1:0]   cnt_q;
  logic [1:0]   cnt_d;
  logic         push;
  logic         pop;

  assign push_ready_o = (cnt_q != 2'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];
  assign cnt_d        = cnt_q + 2'(push) - 2'(pop);

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/ato_back.sv */
// Back end: sums one odd harmonic per cycle from the sine and weight ROMs,
// scales by 8/pi^2 and the gain, saturates. Depends on ato_pkg and ato_if.
module ato_back #(
  parameter int unsigned PB   = 32,
  parameter int unsigned STB  = 10,
  parameter int unsigned MAXH = 512
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [2*PB:0]     pop_data_i,
  input  logic [ato_pkg::GAIN_W-1:0] gain_i,
  ato_out_if.source         out_o,
  output ato_pkg::bk_stat_t stat_o
);
  import ato_pkg::*;

  localparam int unsigned QB    = STB - 2;
  localparam int unsigned QSIZE = 1 << QB;
  localparam int unsigned NCW   = $clog2(MAXH + 1);
  localparam int unsigned NIW   = (MAXH > 1) ? $clog2(MAXH) : 1;
  localparam int unsigned HW    = PB + 2;
  localparam logic [HW-1:0] HALF = HW'(1) << (PB - 1);

  typedef enum logic [7:0] {
    BK_IDLE  = 8'b0000_0001,
    BK_RUN   = 8'b0000_0010,
    BK_DRAIN = 8'b0000_0100,
    BK_ABS   = 8'b0000_1000,
    BK_MUL1  = 8'b0001_0000,
    BK_RND1  = 8'b0010_0000,
    BK_MUL2  = 8'b0100_0000,
    BK_OUT   = 8'b1000_0000
  } bk_state_e;

  // Weight ROM: round(2^30 / h^2), h = 2n + 1
  logic [COEF_W-1:0] coef_rom [MAXH];
  for (genvar g = 0; g < MAXH; g++) begin : g_coef
    localparam logic [63:0] HH = 64'((2 * g + 1) * (2 * g + 1));
    localparam logic [63:0] CV = ((64'd1 << 30) + HH / 2) / HH;
    assign coef_rom[g] = CV[COEF_W-1:0];
  end

  // Quarter-wave sine ROM, positions 0 .. QSIZE inclusive
  logic [SINE_W-1:0] sin_rom [QSIZE+1];
  for (genvar g = 0; g <= QSIZE; g++) begin : g_sine
    localparam logic [SINE_W-1:0] SV = sine_mag(32'(g), 32'(QB));
    assign sin_rom[g] = SV;
  end

  bk_state_e state_q, state_d;

  logic [PB-1:0]  hp_q;
  logic [PB-1:0]  phase2_q;
  logic [HW-1:0]  hs_q;
  logic [HW-1:0]  step2_q;
  logic [NCW-1:0] n_q;

  logic [STB-1:0] idx;
  logic [1:0]     quad;
  logic [QB-1:0]  r;
  logic [QB:0]    pos;
  logic           go;
  logic           take;
  logic           mute;
  logic [PB-1:0]  in_phase;
  logic [PB-1:0]  in_step;

  logic              vb_q, vc_q;
  logic [COEF_W-1:0] coef_b_q;
  logic [SINE_W-1:0] sin_b_q;
  logic              neg_b_q, neg_c_q;
  logic [PROD_W-1:0] prod_c_q;
  logic signed [ACC_W-1:0] acc_q;

  logic [ACC_W-1:0]   mag_q;
  logic               neg_q;
  logic [SCL_P_W-1:0] pl_q, ph_q;
  logic [63:0]        sum1;
  logic [M1_W-1:0]    m1_q;
  logic [47:0]        p2;
  logic [M2_W-1:0]    m2_q;
  logic [SAMPLE_W-1:0] sat;

  logic                       out_valid_q;
  logic                       out_valid_d;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       load;

  assign in_phase = pop_data_i[PB-1:0];
  assign in_step  = pop_data_i[2*PB-1:PB];
  assign mute     = pop_data_i[2*PB];

  assign pop_ready_o = (state_q == BK_IDLE);
  assign take        = pop_valid_i && pop_ready_o;

  // Fold the harmonic phase onto the quarter wave
  assign idx  = hp_q[PB-1 -: STB];
  assign quad = idx[STB-1 -: 2];
  assign r    = idx[QB-1:0];
  assign pos  = quad[0] ? ((QB+1)'(QSIZE) - (QB+1)'(r)) : (QB+1)'(r);

  assign go = (state_q == BK_RUN) && (n_q < NCW'(MAXH)) && (hs_q < HALF);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE:  if (take) state_d = mute ? BK_ABS : BK_RUN;
      BK_RUN:   if (!go) state_d = BK_DRAIN;
      BK_DRAIN: if (!vb_q && !vc_q) state_d = BK_ABS;
      BK_ABS:   state_d = BK_MUL1;
      BK_MUL1:  state_d = BK_RND1;
      BK_RND1:  state_d = BK_MUL2;
      BK_MUL2:  state_d = BK_OUT;
      BK_OUT:   if (load) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      vb_q     <= 1'b0;
      vc_q     <= 1'b0;
      n_q      <= '0;
      hp_q     <= '0;
      phase2_q <= '0;
      hs_q     <= '0;
      step2_q  <= '0;
    end else begin
      state_q <= state_d;
      vb_q    <= go;
      vc_q    <= vb_q;
      if (take) begin
        n_q      <= '0;
        hp_q     <= in_phase;
        phase2_q <= in_phase << 1;
        hs_q     <= HW'(in_step);
        step2_q  <= HW'(in_step) << 1;
      end else if (go) begin
        n_q  <= n_q + NCW'(1);
        hp_q <= hp_q + phase2_q;
        hs_q <= hs_q + step2_q;
      end
    end
  end

  // Harmonic pipeline: ROM read, product, accumulate
  always_ff @(posedge clk_i) begin
    if (go) begin
      coef_b_q <= coef_rom[n_q[NIW-1:0]];
      sin_b_q  <= sin_rom[pos];
      neg_b_q  <= quad[1] ^ n_q[0];
    end
    prod_c_q <= PROD_W'(coef_b_q) * PROD_W'(sin_b_q);
    neg_c_q  <= neg_b_q;
    if (take) begin
      acc_q <= '0;
    end else if (vc_q) begin
      acc_q <= neg_c_q ? acc_q - $signed(ACC_W'(prod_c_q))
                       : acc_q + $signed(ACC_W'(prod_c_q));
    end
  end

  // Scale: |sum| * 8/pi^2 in two partial products, then the gain
  assign sum1 = (64'(ph_q) << SCL_LO_W) + 64'(pl_q) + (64'd1 << 30);
  assign p2   = 48'(m1_q) * 48'(gain_i) + (48'd1 << 30);

  always_ff @(posedge clk_i) begin
    if (state_q == BK_ABS) begin
      neg_q <= acc_q[ACC_W-1];
      mag_q <= acc_q[ACC_W-1] ? $unsigned(-acc_q) : $unsigned(acc_q);
    end
    if (state_q == BK_MUL1) begin
      pl_q <= SCL_P_W'(mag_q[SCL_LO_W-1:0]) * SCL_P_W'(TRI_SCALE_Q16);
      ph_q <= SCL_P_W'(mag_q[ACC_W-1:SCL_LO_W]) * SCL_P_W'(TRI_SCALE_Q16);
    end
    if (state_q == BK_RND1) begin
      m1_q <= sum1[62:31];
    end
    if (state_q == BK_MUL2) begin
      m2_q <= p2[47:31];
    end
  end

  always_comb begin
    if (neg_q) begin
      sat = (m2_q > 17'd32768) ? SAMPLE_MIN : SAMPLE_W'(-$signed({1'b0, m2_q}));
    end else begin
      sat = (m2_q > 17'd32767) ? SAMPLE_MAX : m2_q[SAMPLE_W-1:0];
    end
  end

  // Output register: hold the result until the receiver takes it
  assign load        = (state_q == BK_OUT) && (!out_valid_q || out_o.ready);
  assign out_valid_d = load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sample_q <= $signed(sat);
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.sample = sample_q;

  assign stat_o.busy           = (state_q != BK_IDLE);
  assign stat_o.result_pending = (state_q == BK_OUT);

endmodule
